// ===== hw/rtl/eas_pkg.sv =====
// shared types and constants for the embedded audio sample extractor
package eas_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_AUDIO_GROUP  = 2'd0,
    CFG_CHANNEL_PAIR = 2'd1,
    CFG_MAX_SAMPLES  = 2'd2
  } cfg_idx_e;

  // channel pair codes
  localparam logic [1:0] PAIR_CLEAR = 2'd1;
  localparam logic [1:0] PAIR_SET   = 2'd2;

  // configuration reset values
  localparam logic [7:0]  AUDIO_GROUP_RST  = 8'd1;
  localparam logic [1:0]  CHANNEL_PAIR_RST = PAIR_CLEAR;
  localparam logic [15:0] MAX_SAMPLES_RST  = 16'd2048;

  // block number that wraps back to zero
  localparam logic [7:0] BLOCK_WRAP = 8'hff;

  // largest rounded sample
  localparam logic signed [16:0] SAMPLE_POS_OVF = 17'sd32768;
  localparam logic signed [15:0] SAMPLE_POS_MAX = 16'sh7fff;

  typedef struct packed {
    logic [7:0]  audio_group;
    logic [1:0]  channel_pair;
    logic [15:0] max_samples;
  } cfg_t;

  typedef struct packed {
    logic [9:0] word_first;
    logic [9:0] word_second;
    logic [9:0] word_third;
    logic [7:0] packet_group;
    logic [7:0] packet_block;
    logic [7:0] word_count;
    logic       packet_first;
  } item_t;

  typedef struct packed {
    logic               sample_valid;
    logic               right_channel;
    logic [15:0]        sample_index;
    logic               store_enable;
    logic signed [15:0] sample_value;
    logic               block_discontinuity;
    logic               malformed_packet;
  } result_t;

endpackage

// ===== hw/rtl/eas_cfg_regs.sv =====
// configuration registers of the sample extractor
module eas_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output eas_pkg::cfg_t       cfg_o
);

  eas_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        eas_pkg::CFG_AUDIO_GROUP:  cfg_d.audio_group  = cfg_data_i[7:0];
        eas_pkg::CFG_CHANNEL_PAIR: cfg_d.channel_pair = cfg_data_i[1:0];
        eas_pkg::CFG_MAX_SAMPLES:  cfg_d.max_samples  = cfg_data_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.audio_group  <= eas_pkg::AUDIO_GROUP_RST;
      cfg_q.channel_pair <= eas_pkg::CHANNEL_PAIR_RST;
      cfg_q.max_samples  <= eas_pkg::MAX_SAMPLES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/eas_in_stage.sv =====
// input register stage holding one sample word
module eas_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  eas_pkg::item_t  item_i,
  output logic            stage_valid_o,
  input  logic            stage_ready_i,
  output eas_pkg::item_t  item_o
);

  logic           valid_q, valid_d;
  eas_pkg::item_t item_q;

  // stage can load when empty or when its word moves on
  assign in_ready_o    = !valid_q || stage_ready_i;
  assign stage_valid_o = valid_q;
  assign item_o        = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== hw/rtl/eas_decode.sv =====
// sample decode, rounding, channel counters and block continuity check
module eas_decode #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  eas_pkg::cfg_t    cfg_i,
  input  eas_pkg::item_t   item_i,
  input  logic             advance_i,
  output eas_pkg::result_t result_o
);

  localparam int unsigned CmpW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] left_q, left_d, right_q, right_d;
  logic [7:0]            last_block_q, last_block_d;

  logic [3:0]            digit_sum;
  logic [2:0]            digit_fold;
  logic                  wc_multiple;
  logic                  group_match;
  logic                  block_check;
  logic                  pair_bit;
  logic                  pair_match;
  logic                  take_sample;
  logic                  is_right;
  logic [19:0]           raw;
  logic signed [20:0]    biased;
  logic signed [20:0]    toward_zero;
  logic signed [16:0]    quot;
  logic signed [15:0]    rounded;
  logic [COUNT_BITS-1:0] idx;
  logic [CmpW-1:0]       idx_ext;
  logic [CmpW-1:0]       max_ext;

  // word count modulo 3 by folding base-4 digits (4 = 1 mod 3)
  always_comb begin
    digit_sum = 4'(item_i.word_count[1:0]) + 4'(item_i.word_count[3:2])
              + 4'(item_i.word_count[5:4]) + 4'(item_i.word_count[7:6]);
    digit_fold  = 3'(digit_sum[1:0]) + 3'(digit_sum[3:2]);
    wc_multiple = (digit_fold == 3'd0) || (digit_fold == 3'd3) || (digit_fold == 3'd6);
  end

  // packet filter and pair select
  always_comb begin
    group_match = wc_multiple && (item_i.packet_group == cfg_i.audio_group);
    block_check = group_match && item_i.packet_first && (item_i.packet_block != 8'd0);
    pair_bit    = item_i.word_first[2];
    pair_match  = (pair_bit && (cfg_i.channel_pair == eas_pkg::PAIR_SET))
               || (!pair_bit && (cfg_i.channel_pair == eas_pkg::PAIR_CLEAR));
    take_sample = group_match && (item_i.word_count != 8'd0) && pair_match;
    is_right    = item_i.word_first[1];
  end

  // gather 20-bit sample, add 8, divide by 16 toward zero, clamp top
  always_comb begin
    raw         = {item_i.word_third[4:0], item_i.word_second[8:0],
                   item_i.word_first[8:4], 1'b0};
    biased      = $signed({raw[19], raw}) + 21'sd8;
    toward_zero = biased[20] ? (biased + 21'sd15) : biased;
    quot        = toward_zero[20:4];
    rounded     = (quot == eas_pkg::SAMPLE_POS_OVF) ? eas_pkg::SAMPLE_POS_MAX
                                                    : quot[15:0];
  end

  // channel position and buffer fit
  always_comb begin
    idx     = is_right ? right_q : left_q;
    idx_ext = CmpW'(idx);
    max_ext = CmpW'(cfg_i.max_samples);
  end

  // result word
  always_comb begin
    result_o = '0;
    if (!wc_multiple) begin
      result_o.malformed_packet = 1'b1;
    end else if (group_match) begin
      result_o.block_discontinuity =
        block_check && ((9'(last_block_q) + 9'd1) != 9'(item_i.packet_block));
      if (take_sample) begin
        result_o.sample_valid  = 1'b1;
        result_o.right_channel = is_right;
        result_o.sample_index  = idx_ext[15:0];
        result_o.store_enable  = idx_ext < max_ext;
        result_o.sample_value  = rounded;
      end
    end
  end

  // state update when the word leaves for the output register
  always_comb begin
    left_d       = left_q;
    right_d      = right_q;
    last_block_d = last_block_q;
    if (advance_i) begin
      if (block_check) begin
        last_block_d = (item_i.packet_block == eas_pkg::BLOCK_WRAP) ? 8'd0
                                                                   : item_i.packet_block;
      end
      if (take_sample && is_right) begin
        right_d = right_q + COUNT_BITS'(1);
      end
      if (take_sample && !is_right) begin
        left_d = left_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      right_q      <= '0;
      last_block_q <= '0;
    end else begin
      left_q       <= left_d;
      right_q      <= right_d;
      last_block_q <= last_block_d;
    end
  end

endmodule

// ===== hw/rtl/eas_out_stage.sv =====
// output register holding one result word
module eas_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              stage_valid_i,
  output logic              stage_ready_o,
  input  eas_pkg::result_t  result_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output eas_pkg::result_t  result_o
);

  logic             valid_q, valid_d;
  eas_pkg::result_t result_q;

  // loads when empty or when the current word is taken
  assign stage_ready_o = !valid_q || out_ready_i;
  assign out_valid_o   = valid_q;
  assign result_o      = result_q;

  always_comb begin
    valid_d = valid_q;
    if (stage_ready_o) begin
      valid_d = stage_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (stage_ready_o && stage_valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ===== hw/rtl/embedded_audio_sample_extractor_unit.sv =====
// top level of the embedded audio sample extractor
//
// Takes one three-word audio sample of an ancillary audio packet per word on
// the input channel (in_valid_i / in_ready_o) together with the packet's group,
// block number, word count and first-in-packet flag, and returns exactly one
// result word per input word on the output channel (out_valid_o / out_ready_i).
// Samples of the configured group and channel pair come out rounded to 16 bits
// with their per-channel index and a buffer-fit flag; block number continuity
// is checked on the first word of each packet of that group with a nonzero block.
// A word passes an input register, then decode into the output register.
// One word per cycle unless stalled; the only feedback is the channel counters
// and last block number, updated as a word moves into the output register.
// When the receiver stalls the output register holds its word, the input
// register fills behind it, and in_ready_o drops once both are occupied.
// Reset clears both pipeline valids, the counters and the last block number,
// and loads the configuration registers with their defaults. Configuration is
// written by the user through cfg_valid_i / cfg_index_i / cfg_data_i only while
// the pipeline is empty, unenforced by the block; cfg_ready_o is always high.
module embedded_audio_sample_extractor_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [9:0]         word_first_i,
  input  logic [9:0]         word_second_i,
  input  logic [9:0]         word_third_i,
  input  logic [7:0]         packet_group_i,
  input  logic [7:0]         packet_block_i,
  input  logic [7:0]         word_count_i,
  input  logic               packet_first_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sample_valid_o,
  output logic               right_channel_o,
  output logic [15:0]        sample_index_o,
  output logic               store_enable_o,
  output logic signed [15:0] sample_value_o,
  output logic               block_discontinuity_o,
  output logic               malformed_packet_o
);

  eas_pkg::cfg_t    cfg;
  eas_pkg::item_t   item_in, item_stage;
  eas_pkg::result_t result_dec, result_out;
  logic             stage_valid, stage_ready;

  // configuration registers
  eas_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input word packing
  always_comb begin
    item_in.word_first   = word_first_i;
    item_in.word_second  = word_second_i;
    item_in.word_third   = word_third_i;
    item_in.packet_group = packet_group_i;
    item_in.packet_block = packet_block_i;
    item_in.word_count   = word_count_i;
    item_in.packet_first = packet_first_i;
  end

  eas_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .item_i        (item_in),
    .stage_valid_o (stage_valid),
    .stage_ready_i (stage_ready),
    .item_o        (item_stage)
  );

  eas_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (item_stage),
    .advance_i (stage_valid && stage_ready),
    .result_o  (result_dec)
  );

  eas_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_ready_o (stage_ready),
    .result_i      (result_dec),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_o      (result_out)
  );

  // result word unpacking
  assign sample_valid_o        = result_out.sample_valid;
  assign right_channel_o       = result_out.right_channel;
  assign sample_index_o        = result_out.sample_index;
  assign store_enable_o        = result_out.store_enable;
  assign sample_value_o        = result_out.sample_value;
  assign block_discontinuity_o = result_out.block_discontinuity;
  assign malformed_packet_o    = result_out.malformed_packet;

endmodule

// ===== hw/rtl/eas_checker.sv =====
// port-level checks for the sample extractor and their bind
module eas_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               sample_valid_o,
  input logic               right_channel_o,
  input logic [15:0]        sample_index_o,
  input logic               store_enable_o,
  input logic signed [15:0] sample_value_o,
  input logic               block_discontinuity_o,
  input logic               malformed_packet_o
);

  // a stalled result word holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_value_o)
      && $stable(sample_index_o) && $stable(sample_valid_o))
    else $error("stalled result word changed");

  // a malformed packet word carries nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && malformed_packet_o |-> !sample_valid_o && !block_discontinuity_o)
    else $error("malformed word carries sample or block flag");

  // a word without a sample has zero sample fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> !right_channel_o && !store_enable_o
      && (sample_index_o == 16'd0) && (sample_value_o == 16'sd0))
    else $error("sample fields set without a sample");

  // rounding never reaches the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o |-> sample_value_o != 16'sh8000)
    else $error("rounded sample out of range");

  // with both stages full and the receiver stalled the result word stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !in_ready_o |=> out_valid_o)
    else $error("result word lost under stall");

endmodule

bind embedded_audio_sample_extractor_unit eas_checker u_eas_checker (.*);

// ===== dv/eas_sample_checker.sv =====
// word monitor, sample predictor and result scoreboard for the sample extractor
module eas_sample_checker #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  eas_pkg::item_t   in_word_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  eas_pkg::result_t out_word_i,
  output int               mismatch_cnt_o,
  output int               pending_o,
  output int               word_cnt_o,
  output int               sample_cnt_o,
  output int               stored_cnt_o,
  output int               malformed_cnt_o,
  output int               break_cnt_o
);

  // shadow configuration
  logic [7:0]  group_sel;
  logic [1:0]  pair_sel;
  logic [15:0] capacity;

  // shadow channel positions and block tracking
  logic [COUNT_BITS-1:0] left_pos;
  logic [COUNT_BITS-1:0] right_pos;
  logic [7:0]            prev_block;

  eas_pkg::result_t expected_q[$];

  int mismatches = 0;
  int pending    = 0;
  int words      = 0;
  int samples    = 0;
  int stored     = 0;
  int malformed  = 0;
  int breaks     = 0;

  assign mismatch_cnt_o  = mismatches;
  assign pending_o       = pending;
  assign word_cnt_o      = words;
  assign sample_cnt_o    = samples;
  assign stored_cnt_o    = stored;
  assign malformed_cnt_o = malformed;
  assign break_cnt_o     = breaks;

  // expected result of one input word, advancing the shadow state
  function automatic eas_pkg::result_t predict_word(eas_pkg::item_t w);
    eas_pkg::result_t      r;
    logic                  pair_hit;
    logic                  is_right;
    logic [19:0]           raw;
    int                    full;
    int                    rnd;
    logic [COUNT_BITS-1:0] pos;
    r = '0;
    if (w.word_count % 8'd3 != 8'd0) begin
      r.malformed_packet = 1'b1;
      return r;
    end
    if (w.packet_group != group_sel) begin
      return r;
    end
    // block continuity on the first word of a packet
    if (w.packet_first && w.packet_block != 8'd0) begin
      r.block_discontinuity = (9'(prev_block) + 9'd1) != 9'(w.packet_block);
      prev_block = (w.packet_block == eas_pkg::BLOCK_WRAP) ? 8'd0 : w.packet_block;
    end
    // an empty packet carries no samples
    if (w.word_count == 8'd0) begin
      return r;
    end
    pair_hit = (w.word_first[2] && pair_sel == eas_pkg::PAIR_SET) ||
               (!w.word_first[2] && pair_sel == eas_pkg::PAIR_CLEAR);
    if (!pair_hit) begin
      return r;
    end
    // gather the 20-bit sample, round to 16 bits toward zero
    raw  = {w.word_third[4:0], w.word_second[8:0], w.word_first[8:4], 1'b0};
    full = $signed({{12{raw[19]}}, raw});
    rnd  = (full + 8) / 16;
    if (rnd > int'(eas_pkg::SAMPLE_POS_MAX)) begin
      rnd = int'(eas_pkg::SAMPLE_POS_MAX);
    end
    is_right = w.word_first[1];
    pos      = is_right ? right_pos : left_pos;
    r.sample_valid  = 1'b1;
    r.right_channel = is_right;
    r.sample_index  = 16'(pos);
    r.store_enable  = pos < capacity;
    r.sample_value  = 16'(rnd);
    if (is_right) begin
      right_pos = right_pos + 1'b1;
    end else begin
      left_pos = left_pos + 1'b1;
    end
    return r;
  endfunction

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk_i) begin
    eas_pkg::result_t exp_w;
    if (!rst_ni) begin
      group_sel  = eas_pkg::AUDIO_GROUP_RST;
      pair_sel   = eas_pkg::CHANNEL_PAIR_RST;
      capacity   = eas_pkg::MAX_SAMPLES_RST;
      left_pos   = '0;
      right_pos  = '0;
      prev_block = 8'd0;
      expected_q.delete();
    end else begin
      // result word against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none, got value %0d",
                   $time, out_word_i.sample_value);
          mismatches++;
        end else begin
          exp_w = expected_q.pop_front();
          compare_field("sample_valid", exp_w.sample_valid, out_word_i.sample_valid);
          compare_field("right_channel", exp_w.right_channel, out_word_i.right_channel);
          compare_field("sample_index", exp_w.sample_index, out_word_i.sample_index);
          compare_field("store_enable", exp_w.store_enable, out_word_i.store_enable);
          compare_field("sample_value", exp_w.sample_value, out_word_i.sample_value);
          compare_field("block_discontinuity", exp_w.block_discontinuity,
                        out_word_i.block_discontinuity);
          compare_field("malformed_packet", exp_w.malformed_packet,
                        out_word_i.malformed_packet);
        end
      end
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          eas_pkg::CFG_AUDIO_GROUP:  group_sel = cfg_data_i[7:0];
          eas_pkg::CFG_CHANNEL_PAIR: pair_sel  = cfg_data_i[1:0];
          eas_pkg::CFG_MAX_SAMPLES:  capacity  = cfg_data_i;
          default: ;
        endcase
      end
      // accepted input word
      if (in_valid_i && in_ready_i) begin
        exp_w = predict_word(in_word_i);
        expected_q.push_back(exp_w);
        words++;
        if (exp_w.sample_valid) samples++;
        if (exp_w.store_enable) stored++;
        if (exp_w.malformed_packet) malformed++;
        if (exp_w.block_discontinuity) breaks++;
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== dv/tb_embedded_audio_sample_extractor_unit.sv =====
// testbench top: clock, reset, stimulus and verdict for the sample extractor
module tb_embedded_audio_sample_extractor_unit;

  localparam int unsigned COUNT_BITS = 16;

  // channel pair settings that select nothing
  localparam logic [1:0] PAIR_NONE = 2'd0;
  localparam logic [1:0] PAIR_BOTH = 2'd3;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = eas_pkg::CFG_AUDIO_GROUP;
  logic [15:0]      cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  eas_pkg::item_t   in_word   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  eas_pkg::result_t out_word;

  int mismatches, pending, words, samples, stored, malformed, breaks;

  // stimulus state
  logic [7:0] cur_group = eas_pkg::AUDIO_GROUP_RST;
  logic [1:0] cur_pair  = eas_pkg::CHANNEL_PAIR_RST;
  logic [7:0] next_blk  = 8'd1;
  logic       quiet     = 1'b0;
  logic       send_gaps = 1'b1;
  logic       recv_gaps = 1'b1;
  int         sent      = 0;

  // clock
  always #6 clk = ~clk;

  embedded_audio_sample_extractor_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .word_first_i         (in_word.word_first),
    .word_second_i        (in_word.word_second),
    .word_third_i         (in_word.word_third),
    .packet_group_i       (in_word.packet_group),
    .packet_block_i       (in_word.packet_block),
    .word_count_i         (in_word.word_count),
    .packet_first_i       (in_word.packet_first),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .sample_valid_o       (out_word.sample_valid),
    .right_channel_o      (out_word.right_channel),
    .sample_index_o       (out_word.sample_index),
    .store_enable_o       (out_word.store_enable),
    .sample_value_o       (out_word.sample_value),
    .block_discontinuity_o(out_word.block_discontinuity),
    .malformed_packet_o   (out_word.malformed_packet)
  );

  eas_sample_checker #(
    .COUNT_BITS(COUNT_BITS)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_word_i      (in_word),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_word_i     (out_word),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .word_cnt_o     (words),
    .sample_cnt_o   (samples),
    .stored_cnt_o   (stored),
    .malformed_cnt_o(malformed),
    .break_cnt_o    (breaks)
  );

  function automatic eas_pkg::item_t audio_word(
    logic [9:0] w0, logic [9:0] w1, logic [9:0] w2,
    logic [7:0] grp, logic [7:0] blk, logic [7:0] wc,
    logic first);
    eas_pkg::item_t w;
    w.word_first   = w0;
    w.word_second  = w1;
    w.word_third   = w2;
    w.packet_group = grp;
    w.packet_block = blk;
    w.word_count   = wc;
    w.packet_first = first;
    return w;
  endfunction

  // one register write, started and finished at a falling edge
  task automatic write_reg(eas_pkg::cfg_idx_e idx, logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // write all registers, junk in the unused upper bits
  task automatic configure(logic [7:0] grp, logic [1:0] pair, logic [15:0] cap);
    write_reg(eas_pkg::CFG_AUDIO_GROUP, {8'($urandom), grp});
    write_reg(eas_pkg::CFG_CHANNEL_PAIR, {14'($urandom), pair});
    write_reg(eas_pkg::CFG_MAX_SAMPLES, cap);
    cur_group = grp;
    cur_pair  = pair;
  endtask

  // one input word, with an optional gap in front of it
  task automatic send_word(eas_pkg::item_t w);
    if (!quiet && send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // a well formed packet with random sample content
  task automatic send_packet();
    eas_pkg::item_t w;
    int             n;
    int             lim;
    logic [7:0]     wc;
    logic           drop_first;
    w = '0;
    w.packet_group = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_group;
    case ($urandom_range(0, 15))
      0:       w.packet_block = 8'd0;
      1:       w.packet_block = 8'($urandom);
      default: w.packet_block = next_blk;
    endcase
    if (w.packet_block != 8'd0) begin
      next_blk = (w.packet_block == eas_pkg::BLOCK_WRAP) ? 8'd1 : w.packet_block + 8'd1;
    end
    wc = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'(3 * $urandom_range(1, 85));
    w.word_count = wc;
    lim = (wc / 3 < 6) ? int'(wc / 3) : 6;
    n = (wc == 8'd0) ? 1 : $urandom_range(1, lim);
    drop_first = ($urandom_range(0, 19) == 0);
    for (int i = 0; i < n; i++) begin
      w.word_first = 10'($urandom);
      if ($urandom_range(0, 4) != 0) begin
        w.word_first[2] = (cur_pair == eas_pkg::PAIR_SET);
      end
      w.word_second  = 10'($urandom);
      w.word_third   = 10'($urandom);
      w.packet_first = (i == 0) && !drop_first;
      send_word(w);
    end
  endtask

  // a stray word with random fields
  task automatic send_noise();
    eas_pkg::item_t w;
    w.word_first   = 10'($urandom);
    w.word_second  = 10'($urandom);
    w.word_third   = 10'($urandom);
    w.packet_group = $urandom_range(0, 1) ? cur_group : 8'($urandom);
    w.packet_block = 8'($urandom);
    w.word_count   = 8'($urandom);
    w.packet_first = 1'($urandom);
    send_word(w);
  endtask

  // wait for all expected results, then for the pipeline to settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid = 1'b0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  // receiver: ready stretches with random stall bursts
  initial begin
    @(posedge rst_n);
    forever begin
      out_ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (!quiet && recv_gaps) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  // main sequence
  initial begin
    int target;
    int budget;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed words under the reset configuration
    send_word(audio_word(10'h000, 10'h000, 10'h000, 8'd1, 8'd0, 8'd1, 1'b0));
    send_word(audio_word(10'h3ff, 10'h3ff, 10'h3ff, 8'hff, 8'hff, 8'd2, 1'b1));
    send_word(audio_word(10'h040, 10'h000, 10'h000, 8'd1, 8'd3, 8'd254, 1'b1));
    // other group, no block check
    send_word(audio_word(10'h040, 10'h000, 10'h000, 8'd0, 8'd1, 8'd3, 1'b1));
    // empty packet still checks the block
    send_word(audio_word(10'h000, 10'h000, 10'h000, 8'd1, 8'd1, 8'd0, 1'b1));
    // repeated block number, small positive sample
    send_word(audio_word(10'h040, 10'h000, 10'h000, 8'd1, 8'd1, 8'd3, 1'b1));
    // largest sample saturates, upper word bits set
    send_word(audio_word(10'h3f9, 10'h3ff, 10'h3ef, 8'd1, 8'd1, 8'd3, 1'b0));
    // most negative sample on the right channel
    send_word(audio_word(10'h002, 10'h000, 10'h010, 8'd1, 8'd1, 8'd3, 1'b0));
    // pair bit set while the clear pair is selected
    send_word(audio_word(10'h006, 10'h155, 10'h00a, 8'd1, 8'd1, 8'd3, 1'b0));
    // -2 rounds to zero, largest word count
    send_word(audio_word(10'h3fb, 10'h3ff, 10'h3ff, 8'd1, 8'd2, 8'd255, 1'b1));
    // block 255 breaks the run and wraps to zero
    send_word(audio_word(10'h000, 10'h100, 10'h000, 8'd1, 8'hff, 8'd3, 1'b1));
    send_word(audio_word(10'h3f0, 10'h2aa, 10'h015, 8'd1, 8'd1, 8'd6, 1'b1));
    // block number absent
    send_word(audio_word(10'h010, 10'h000, 10'h000, 8'd1, 8'd0, 8'd3, 1'b1));
    send_word(audio_word(10'h020, 10'h000, 10'h000, 8'd1, 8'd5, 8'd3, 1'b1));
    send_word(audio_word(10'h000, 10'h000, 10'h000, 8'd1, 8'd6, 8'd0, 1'b0));
    // -24 rounds to -1
    send_word(audio_word(10'h140, 10'h1ff, 10'h01f, 8'd1, 8'd6, 8'd3, 1'b0));
    send_word(audio_word(10'h142, 10'h1ff, 10'h01f, 8'd1, 8'd6, 8'd3, 1'b0));
    wait_drained();
    next_blk = 8'd6;

    // random phases over a range of settings
    for (int ph = 0; ph < 7; ph++) begin
      budget = 300;
      case (ph)
        0: configure(8'd0, eas_pkg::PAIR_SET, 16'd0);
        1: configure(8'd255, eas_pkg::PAIR_CLEAR, 16'hffff);
        2: configure(8'($urandom), eas_pkg::PAIR_SET, 16'd5);
        3: begin
          configure(8'($urandom), PAIR_NONE, 16'($urandom));
          budget = 80;
        end
        4: begin
          configure(8'($urandom), PAIR_BOTH, 16'($urandom));
          budget = 80;
        end
        5: configure(8'($urandom), eas_pkg::PAIR_CLEAR, 16'($urandom_range(0, 300)));
        default: begin
          configure(8'd1, eas_pkg::PAIR_SET, 16'($urandom_range(100, 600)));
          budget = 330;
        end
      endcase
      quiet     = (ph == 6);
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      target    = sent + budget;
      while (sent < target) begin
        if ($urandom_range(0, 99) < 85) begin
          send_packet();
        end else begin
          send_noise();
        end
      end
      wait_drained();
    end

    $display("covered %0d words: %0d samples (%0d in buffer range), %0d malformed counts,",
             words, samples, stored, malformed);
    $display("%0d block breaks, seven register settings including the extremes", breaks);
    if (mismatches == 0 && pending == 0) begin
      $display("[embedded_audio_sample_extractor_unit] OK");
    end else begin
      $display("[embedded_audio_sample_extractor_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("timeout with %0d results outstanding", pending);
    $display("[embedded_audio_sample_extractor_unit] ERROR");
    $finish;
  end

endmodule
